@@ design/gete_pkg.sv @@
// ----------------------------------------------------------------------------
// gete_pkg
// Shared constants for the graph edge table engine: size defaults, field
// widths, operation codes and result status codes.
// ----------------------------------------------------------------------------
package gete_pkg;

  // Size defaults for the top-level parameters.
  localparam int DEF_MAX_VERTICES = 256;
  localparam int DEF_MAX_EDGES    = 512;

  // Fixed field widths of the item and result channels.
  localparam int MODE_W  = 3;
  localparam int VERT_W  = 8;
  localparam int STAT_W  = 2;
  localparam int RIDX_W  = 9;
  localparam int ECNT_W  = 10;
  localparam int VCNT_W  = 9;

  // Operation codes carried in the mode field.
  localparam logic [MODE_W-1:0] OP_ADD_VERTEX = 3'd0;
  localparam logic [MODE_W-1:0] OP_REM_VERTEX = 3'd1;
  localparam logic [MODE_W-1:0] OP_CONNECT    = 3'd2;
  localparam logic [MODE_W-1:0] OP_DISCONNECT = 3'd3;
  localparam logic [MODE_W-1:0] OP_FIND       = 3'd4;
  localparam logic [MODE_W-1:0] OP_VALIDATE   = 3'd5;

  // Result status codes.
  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_INVALID   = 2'd1;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [STAT_W-1:0] ST_FULL      = 2'd3;

endpackage

@@ design/graph_edge_table_engine.sv @@
// ----------------------------------------------------------------------------
// graph_edge_table_engine
// Undirected graph held as a vertex count and an ordered edge list in memory.
//
// One item on the input channel (in_valid/in_stall) is one operation; each
// item gives exactly one result item on the output channel
// (out_valid/out_stall). Items are worked one at a time, and in_stall is high
// while an operation runs. The edge list sits in a synchronous memory with
// one read and one write port; a one-bit touched flag per vertex sits in a
// second memory used by validate.
// Work per item:
//   add vertex and unused modes: straight to the final step.
//   find, connect: one pipelined pass over the edge memory.
//   remove vertex: one read-modify-write compaction pass.
//   disconnect: search pass, then compaction pass.
//   validate: clear the flags, then per edge a scan of all earlier
//   edges for a repeated pair and the marking of its endpoints, then a
//   count of untouched vertices.
// Reset clears the counts and the channel state; memories are not cleared.
// A finished result waits in the output register while out_stall is high;
// the next item is accepted meanwhile, but its result waits until then.
// ----------------------------------------------------------------------------
module graph_edge_table_engine
  import gete_pkg::*;
#(
  parameter int MAX_VERTICES = DEF_MAX_VERTICES,
  parameter int MAX_EDGES    = DEF_MAX_EDGES
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [MODE_W-1:0] mode,
  input  logic [VERT_W-1:0] vertex_a,
  input  logic [VERT_W-1:0] vertex_b,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [STAT_W-1:0] status,
  output logic [RIDX_W-1:0] result_index,
  output logic [ECNT_W-1:0] invalid_edges,
  output logic [ECNT_W-1:0] self_loops,
  output logic [ECNT_W-1:0] duplicate_edges,
  output logic [VCNT_W-1:0] isolated_vertices,
  output logic [VCNT_W-1:0] vertex_total,
  output logic [ECNT_W-1:0] edge_total
);

  localparam int CW  = $clog2(MAX_EDGES + 1);
  localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int VCW = $clog2(MAX_VERTICES + 1);
  localparam int VW  = $clog2(MAX_VERTICES);

  typedef enum logic [3:0] {
    S_IDLE, S_SRCH, S_CMPT, S_VCLR, S_VORD, S_VOWT, S_VINNER,
    S_VMRKA, S_VMRKB, S_VCNT, S_FIN
  } state_t;

  state_t            state;
  logic [MODE_W-1:0] op;
  logic [VERT_W-1:0] va;
  logic [VERT_W-1:0] vb;
  logic [CW-1:0]     edge_count;
  logic [VCW-1:0]    vertex_count;
  logic [CW-1:0]     idx;
  logic [CW-1:0]     pidx;
  logic [CW-1:0]     fidx;
  logic [CW-1:0]     wptr;
  logic [CW-1:0]     drop_idx;
  logic              pend;
  logic [VCW-1:0]    vidx;
  logic [VERT_W-1:0] cur_a;
  logic [VERT_W-1:0] cur_b;
  logic [CW-1:0]     n_inv;
  logic [CW-1:0]     n_self;
  logic [CW-1:0]     n_dup;
  logic [VCW-1:0]    n_iso;
  logic [STAT_W-1:0] res_status;
  logic [RIDX_W-1:0] res_index;

  // Edge memory: endpoint a in the upper byte, endpoint b in the lower.
  logic [2*VERT_W-1:0] edge_mem [MAX_EDGES];
  logic [2*VERT_W-1:0] edge_rdata;
  logic [2*VERT_W-1:0] edge_wdata;
  logic [EAW-1:0]      edge_raddr;
  logic [EAW-1:0]      edge_waddr;
  logic                edge_we;

  // Touched flag per vertex, used by validate.
  logic          flag_mem [MAX_VERTICES];
  logic          flag_rdata;
  logic          flag_wdata;
  logic [VW-1:0] flag_raddr;
  logic [VW-1:0] flag_waddr;
  logic          flag_we;

  logic [VERT_W-1:0] rd_a;
  logic [VERT_W-1:0] rd_b;
  logic [VERT_W-1:0] adj_a;
  logic [VERT_W-1:0] adj_b;
  logic              pair_hit;
  logic              rd_bad;
  logic              dup_hit;
  logic              keep;
  logic              scan_end;

  assign in_stall = (state != S_IDLE);

  // Decode the entry read in the previous cycle.
  always_comb begin
    rd_a     = edge_rdata[2*VERT_W-1:VERT_W];
    rd_b     = edge_rdata[VERT_W-1:0];
    adj_a    = (rd_a > va) ? rd_a - 1'b1 : rd_a;
    adj_b    = (rd_b > va) ? rd_b - 1'b1 : rd_b;
    pair_hit = (rd_a == va && rd_b == vb) || (rd_a == vb && rd_b == va);
    rd_bad   = (32'(rd_a) >= 32'(vertex_count)) || (32'(rd_b) >= 32'(vertex_count));
    dup_hit  = !rd_bad && (rd_a != rd_b) &&
               ((rd_a == cur_a && rd_b == cur_b) || (rd_a == cur_b && rd_b == cur_a));
    if (op == OP_REM_VERTEX) begin
      keep = (rd_a != va) && (rd_b != va);
    end else begin
      keep = (pidx != drop_idx);
    end
    scan_end = !pend && (idx == edge_count);
  end

  // Memory port control for each state.
  always_comb begin
    edge_raddr = idx[EAW-1:0];
    edge_waddr = wptr[EAW-1:0];
    edge_wdata = {va, vb};
    edge_we    = 1'b0;
    flag_raddr = vidx[VW-1:0];
    flag_waddr = vidx[VW-1:0];
    flag_wdata = 1'b0;
    flag_we    = 1'b0;
    case (state)
      S_SRCH: begin
        if (scan_end && op == OP_CONNECT && 32'(edge_count) < MAX_EDGES) begin
          edge_we    = 1'b1;
          edge_waddr = edge_count[EAW-1:0];
        end
      end
      S_CMPT: begin
        if (pend && keep) begin
          edge_we    = 1'b1;
          edge_wdata = (op == OP_REM_VERTEX) ? {adj_a, adj_b} : edge_rdata;
        end
      end
      S_VCLR: begin
        flag_we = (vidx != vertex_count);
      end
      S_VINNER: begin
        edge_raddr = fidx[EAW-1:0];
      end
      S_VMRKA: begin
        flag_we    = 1'b1;
        flag_wdata = 1'b1;
        flag_waddr = VW'(cur_a);
      end
      S_VMRKB: begin
        flag_we    = 1'b1;
        flag_wdata = 1'b1;
        flag_waddr = VW'(cur_b);
      end
      default: begin
      end
    endcase
  end

  // Edge memory with registered read.
  always_ff @(posedge clk) begin
    if (edge_we) begin
      edge_mem[edge_waddr] <= edge_wdata;
    end
    edge_rdata <= edge_mem[edge_raddr];
  end

  // Vertex flag memory with registered read.
  always_ff @(posedge clk) begin
    if (flag_we) begin
      flag_mem[flag_waddr] <= flag_wdata;
    end
    flag_rdata <= flag_mem[flag_raddr];
  end

  // Operation sequencer and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      edge_count   <= '0;
      vertex_count <= '0;
      pend         <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            op         <= mode;
            va         <= vertex_a;
            vb         <= vertex_b;
            idx        <= '0;
            wptr       <= '0;
            vidx       <= '0;
            pend       <= 1'b0;
            n_inv      <= '0;
            n_self     <= '0;
            n_dup      <= '0;
            n_iso      <= '0;
            res_status <= ST_OK;
            res_index  <= '0;
            case (mode)
              OP_ADD_VERTEX: begin
                if (32'(vertex_count) >= MAX_VERTICES) begin
                  res_status <= ST_FULL;
                end else begin
                  res_index    <= RIDX_W'(vertex_count);
                  vertex_count <= vertex_count + 1'b1;
                end
                state <= S_FIN;
              end
              OP_REM_VERTEX: begin
                if (32'(vertex_a) >= 32'(vertex_count)) begin
                  res_status <= ST_INVALID;
                  state      <= S_FIN;
                end else begin
                  state <= S_CMPT;
                end
              end
              OP_CONNECT: begin
                if (vertex_a == vertex_b || 32'(vertex_a) >= 32'(vertex_count) ||
                    32'(vertex_b) >= 32'(vertex_count)) begin
                  res_status <= ST_INVALID;
                  state      <= S_FIN;
                end else begin
                  state <= S_SRCH;
                end
              end
              OP_DISCONNECT, OP_FIND: begin
                state <= S_SRCH;
              end
              OP_VALIDATE: begin
                state <= S_VCLR;
              end
              default: begin
                res_status <= ST_INVALID;
                state      <= S_FIN;
              end
            endcase
          end
        end

        // Pipelined pass looking for the pair in either order.
        S_SRCH: begin
          pend <= 1'b0;
          if (idx < edge_count && !(pend && pair_hit)) begin
            idx  <= idx + 1'b1;
            pidx <= idx;
            pend <= 1'b1;
          end
          if (pend && pair_hit) begin
            res_index <= RIDX_W'(pidx);
            if (op == OP_DISCONNECT) begin
              drop_idx <= pidx;
              idx      <= '0;
              wptr     <= '0;
              pend     <= 1'b0;
              state    <= S_CMPT;
            end else begin
              state <= S_FIN;
            end
          end else if (scan_end) begin
            if (op == OP_CONNECT) begin
              if (32'(edge_count) >= MAX_EDGES) begin
                res_status <= ST_FULL;
              end else begin
                res_index  <= RIDX_W'(edge_count);
                edge_count <= edge_count + 1'b1;
              end
            end else begin
              res_status <= ST_NOT_FOUND;
            end
            state <= S_FIN;
          end
        end

        // Compaction pass: kept entries are written back at the write pointer.
        S_CMPT: begin
          pend <= 1'b0;
          if (idx < edge_count) begin
            idx  <= idx + 1'b1;
            pidx <= idx;
            pend <= 1'b1;
          end
          if (pend && keep) begin
            wptr <= wptr + 1'b1;
          end
          if (scan_end) begin
            edge_count <= wptr;
            if (op == OP_REM_VERTEX) begin
              vertex_count <= vertex_count - 1'b1;
            end
            state <= S_FIN;
          end
        end

        // Validate: clear the flags of all live vertices.
        S_VCLR: begin
          if (vidx == vertex_count) begin
            idx   <= '0;
            state <= S_VORD;
          end else begin
            vidx <= vidx + 1'b1;
          end
        end

        // Validate: read the next outer edge.
        S_VORD: begin
          if (idx == edge_count) begin
            vidx  <= '0;
            pend  <= 1'b0;
            state <= S_VCNT;
          end else begin
            state <= S_VOWT;
          end
        end

        // Validate: classify the outer edge.
        S_VOWT: begin
          cur_a <= rd_a;
          cur_b <= rd_b;
          if (rd_bad) begin
            n_inv <= n_inv + 1'b1;
            idx   <= idx + 1'b1;
            state <= S_VORD;
          end else if (rd_a == rd_b) begin
            n_self <= n_self + 1'b1;
            idx    <= idx + 1'b1;
            state  <= S_VORD;
          end else begin
            fidx  <= '0;
            pend  <= 1'b0;
            state <= S_VINNER;
          end
        end

        // Validate: scan the earlier edges for the same unordered pair.
        S_VINNER: begin
          pend <= 1'b0;
          if (fidx < idx && !(pend && dup_hit)) begin
            fidx <= fidx + 1'b1;
            pend <= 1'b1;
          end
          if (pend && dup_hit) begin
            n_dup <= n_dup + 1'b1;
            idx   <= idx + 1'b1;
            pend  <= 1'b0;
            state <= S_VORD;
          end else if (!pend && fidx == idx) begin
            state <= S_VMRKA;
          end
        end

        S_VMRKA: begin
          state <= S_VMRKB;
        end

        S_VMRKB: begin
          idx   <= idx + 1'b1;
          state <= S_VORD;
        end

        // Validate: count vertices whose flag stayed clear.
        S_VCNT: begin
          pend <= 1'b0;
          if (vidx < vertex_count) begin
            vidx <= vidx + 1'b1;
            pend <= 1'b1;
          end
          if (pend && !flag_rdata) begin
            n_iso <= n_iso + 1'b1;
          end
          if (!pend && vidx == vertex_count) begin
            state <= S_FIN;
          end
        end

        // Hand the result to the output register once it is free.
        S_FIN: begin
          if (!out_valid || !out_stall) begin
            out_valid         <= 1'b1;
            status            <= res_status;
            result_index      <= res_index;
            invalid_edges     <= ECNT_W'(n_inv);
            self_loops        <= ECNT_W'(n_self);
            duplicate_edges   <= ECNT_W'(n_dup);
            isolated_vertices <= VCNT_W'(n_iso);
            vertex_total      <= VCNT_W'(vertex_count);
            edge_total        <= ECNT_W'(edge_count);
            state             <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  // The counts never pass the table sizes.
  a_edge_bound: assert property (@(posedge clk) disable iff (rst)
    32'(edge_count) <= MAX_EDGES)
    else $error("edge count exceeds table size");

  a_vert_bound: assert property (@(posedge clk) disable iff (rst)
    32'(vertex_count) <= MAX_VERTICES)
    else $error("vertex count exceeds table size");

  // A new result is loaded only from the final step of an operation.
  a_out_from_fin: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !$past(out_valid)) |-> $past(state == S_FIN))
    else $error("result appeared outside the final step");

  // Compaction never writes ahead of the read pointer.
  a_cmpt_order: assert property (@(posedge clk) disable iff (rst)
    (state == S_CMPT) |-> (wptr <= idx))
    else $error("compaction write pointer passed read pointer");
`endif

endmodule

@@ tb/sv/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the graph edge table engine. A behavioral model of
// the vertex count and the ordered edge list predicts every result. Named
// tests run in turn: directed corner cases, random operation mixes under
// three idling profiles, and a fill of the vertex table to its limit.
// ----------------------------------------------------------------------------
module testbench;
  import gete_pkg::*;

  localparam int NV = DEF_MAX_VERTICES;
  localparam int NE = DEF_MAX_EDGES;
  localparam logic [MODE_W-1:0] OP_SPARE_6 = 3'd6;
  localparam logic [MODE_W-1:0] OP_SPARE_7 = 3'd7;

  typedef struct {
    logic [STAT_W-1:0] stat;
    logic [RIDX_W-1:0] ridx;
    logic [ECNT_W-1:0] n_inv;
    logic [ECNT_W-1:0] n_self;
    logic [ECNT_W-1:0] n_dup;
    logic [VCNT_W-1:0] n_iso;
    logic [VCNT_W-1:0] vtot;
    logic [ECNT_W-1:0] etot;
  } graph_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [MODE_W-1:0] mode = '0;
  logic [VERT_W-1:0] vertex_a = '0;
  logic [VERT_W-1:0] vertex_b = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [STAT_W-1:0] status;
  logic [RIDX_W-1:0] result_index;
  logic [ECNT_W-1:0] invalid_edges;
  logic [ECNT_W-1:0] self_loops;
  logic [ECNT_W-1:0] duplicate_edges;
  logic [VCNT_W-1:0] isolated_vertices;
  logic [VCNT_W-1:0] vertex_total;
  logic [ECNT_W-1:0] edge_total;

  // Graph state of the model.
  int unsigned end_a[NE];
  int unsigned end_b[NE];
  int unsigned model_edges = 0;
  int unsigned model_verts = 0;

  graph_result_t pending_results[$];
  int error_count = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  graph_edge_table_engine dut (.*);

  always #5 clk = ~clk;

  // Receiver backpressure.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  function automatic int locate_edge(int unsigned a, int unsigned b);
    for (int e = 0; e < model_edges; e++) begin
      if ((end_a[e] == a && end_b[e] == b) || (end_a[e] == b && end_b[e] == a))
        return e;
    end
    return -1;
  endfunction

  // Applies one operation to the model graph and returns its result.
  function automatic graph_result_t apply_graph_op(logic [MODE_W-1:0] op,
                                                   int unsigned va, int unsigned vb);
    graph_result_t r;
    int found;
    int unsigned w;
    int unsigned a;
    int unsigned b;
    bit dup;
    int unsigned deg[NV];
    r = '{default: '0};
    case (op)
      OP_ADD_VERTEX: begin
        if (model_verts >= NV) r.stat = ST_FULL;
        else begin
          r.ridx = RIDX_W'(model_verts);
          model_verts++;
        end
      end
      OP_REM_VERTEX: begin
        if (va >= model_verts) r.stat = ST_INVALID;
        else begin
          w = 0;
          for (int e = 0; e < model_edges; e++) begin
            a = end_a[e];
            b = end_b[e];
            if (a == va || b == va) continue;
            if (a > va) a--;
            if (b > va) b--;
            end_a[w] = a;
            end_b[w] = b;
            w++;
          end
          model_edges = w;
          model_verts--;
        end
      end
      OP_CONNECT: begin
        if (va == vb || va >= model_verts || vb >= model_verts) r.stat = ST_INVALID;
        else begin
          found = locate_edge(va, vb);
          if (found >= 0) r.ridx = RIDX_W'(found);
          else if (model_edges >= NE) r.stat = ST_FULL;
          else begin
            r.ridx = RIDX_W'(model_edges);
            end_a[model_edges] = va;
            end_b[model_edges] = vb;
            model_edges++;
          end
        end
      end
      OP_DISCONNECT, OP_FIND: begin
        found = locate_edge(va, vb);
        if (found < 0) r.stat = ST_NOT_FOUND;
        else begin
          r.ridx = RIDX_W'(found);
          if (op == OP_DISCONNECT) begin
            for (int e = found; e + 1 < model_edges; e++) begin
              end_a[e] = end_a[e+1];
              end_b[e] = end_b[e+1];
            end
            model_edges--;
          end
        end
      end
      OP_VALIDATE: begin
        for (int v = 0; v < NV; v++) deg[v] = 0;
        for (int e = 0; e < model_edges; e++) begin
          a = end_a[e];
          b = end_b[e];
          if (a >= model_verts || b >= model_verts) begin
            r.n_inv++;
            continue;
          end
          if (a == b) begin
            r.n_self++;
            continue;
          end
          dup = 1'b0;
          for (int f = 0; f < e && !dup; f++) begin
            if (end_a[f] >= model_verts || end_b[f] >= model_verts || end_a[f] == end_b[f])
              continue;
            if ((end_a[f] == a && end_b[f] == b) || (end_a[f] == b && end_b[f] == a))
              dup = 1'b1;
          end
          if (dup) begin
            r.n_dup++;
            continue;
          end
          deg[a]++;
          deg[b]++;
        end
        for (int v = 0; v < model_verts; v++)
          if (deg[v] == 0) r.n_iso++;
      end
      default: r.stat = ST_INVALID;
    endcase
    r.vtot = VCNT_W'(model_verts);
    r.etot = ECNT_W'(model_edges);
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    error_count++;
  endtask

  // Result checker: compares each accepted result with the oldest prediction.
  always @(posedge clk) begin
    graph_result_t x;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("unexpected result item at %0t", $realtime);
        error_count++;
      end else begin
        x = pending_results.pop_front();
        if (status !== x.stat) report_mismatch("status", status, x.stat);
        if (result_index !== x.ridx) report_mismatch("result_index", result_index, x.ridx);
        if (invalid_edges !== x.n_inv) report_mismatch("invalid_edges", invalid_edges, x.n_inv);
        if (self_loops !== x.n_self) report_mismatch("self_loops", self_loops, x.n_self);
        if (duplicate_edges !== x.n_dup)
          report_mismatch("duplicate_edges", duplicate_edges, x.n_dup);
        if (isolated_vertices !== x.n_iso)
          report_mismatch("isolated_vertices", isolated_vertices, x.n_iso);
        if (vertex_total !== x.vtot) report_mismatch("vertex_total", vertex_total, x.vtot);
        if (edge_total !== x.etot) report_mismatch("edge_total", edge_total, x.etot);
      end
    end
  end

  // Sends one item; the prediction is queued when the item is accepted.
  task automatic send_op(logic [MODE_W-1:0] op, logic [VERT_W-1:0] va, logic [VERT_W-1:0] vb);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    mode <= op;
    vertex_a <= va;
    vertex_b <= vb;
    do @(posedge clk); while (in_stall);
    pending_results.push_back(apply_graph_op(op, va, vb));
  endtask

  // Directed corner cases on a tiny graph.
  task automatic test_directed();
    send_op(OP_REM_VERTEX, 8'd0, 8'd0);
    send_op(OP_VALIDATE, 8'd0, 8'd0);
    send_op(OP_FIND, 8'd255, 8'd255);
    send_op(OP_DISCONNECT, 8'd0, 8'd1);
    repeat (4) send_op(OP_ADD_VERTEX, 8'd255, 8'd255);
    send_op(OP_CONNECT, 8'd1, 8'd1);
    send_op(OP_CONNECT, 8'd0, 8'd4);
    send_op(OP_CONNECT, 8'd255, 8'd0);
    send_op(OP_CONNECT, 8'd0, 8'd1);
    send_op(OP_CONNECT, 8'd2, 8'd3);
    send_op(OP_CONNECT, 8'd1, 8'd0);
    send_op(OP_CONNECT, 8'd1, 8'd3);
    send_op(OP_FIND, 8'd3, 8'd2);
    send_op(OP_VALIDATE, 8'd0, 8'd0);
    send_op(OP_SPARE_6, 8'd170, 8'd85);
    send_op(OP_SPARE_7, 8'd85, 8'd170);
    send_op(OP_DISCONNECT, 8'd0, 8'd1);
    send_op(OP_REM_VERTEX, 8'd4, 8'd0);
    send_op(OP_REM_VERTEX, 8'd1, 8'd0);
    send_op(OP_FIND, 8'd1, 8'd2);
    send_op(OP_VALIDATE, 8'd0, 8'd0);
  endtask

  // Random operation mix on a small graph under one idling profile.
  task automatic test_random_mix(int count, int idle_pct, int stall_pct);
    int pick;
    logic [MODE_W-1:0] op;
    logic [VERT_W-1:0] va;
    logic [VERT_W-1:0] vb;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      if (pick < (model_verts < 12 ? 22 : 6)) op = OP_ADD_VERTEX;
      else if (pick < 32) op = OP_REM_VERTEX;
      else if (pick < 66) op = OP_CONNECT;
      else if (pick < 78) op = OP_DISCONNECT;
      else if (pick < 90) op = OP_FIND;
      else if (pick < 97) op = OP_VALIDATE;
      else op = $urandom_range(1) ? OP_SPARE_6 : OP_SPARE_7;
      if ($urandom_range(9) == 0) begin
        va = VERT_W'($urandom_range(255));
        vb = VERT_W'($urandom_range(255));
      end else begin
        va = VERT_W'($urandom_range(model_verts));
        vb = VERT_W'($urandom_range(model_verts));
      end
      send_op(op, va, vb);
    end
  endtask

  // Fills the vertex table, then works at its limit.
  task automatic test_full_tables();
    send_idle_pct = 10;
    recv_stall_pct = 20;
    while (model_verts < NV) send_op(OP_ADD_VERTEX, 8'd0, 8'd0);
    send_op(OP_ADD_VERTEX, 8'd255, 8'd255);
    for (int v = 0; v < 16; v++) begin
      send_op(OP_CONNECT, v[7:0], 8'(v + 1));
    end
    send_op(OP_CONNECT, 8'd0, 8'd200);
    send_op(OP_CONNECT, 8'd255, 8'd254);
    send_op(OP_FIND, 8'd254, 8'd255);
    send_op(OP_VALIDATE, 8'd0, 8'd0);
    send_op(OP_DISCONNECT, 8'd0, 8'd1);
    send_op(OP_REM_VERTEX, 8'd255, 8'd0);
    send_op(OP_REM_VERTEX, 8'd0, 8'd0);
    send_op(OP_VALIDATE, 8'd0, 8'd0);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_random_mix(95, 28, 61);
    test_random_mix(95, 61, 28);
    test_random_mix(95, 0, 0);
    test_full_tables();
    @(posedge clk);
    in_valid <= 1'b0;
    recv_stall_pct = 0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (error_count == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

  // Run limit.
  initial begin
    #200_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
